FILE: hdl/ratio_to_float32_rne_core_defines.svh
// Assertion macros shared by the ratio-to-float pipeline.
// Each check is clocked on the rising edge and is off while reset is held.
`ifndef RATIO_TO_FLOAT32_RNE_CORE_DEFINES_SVH
`define RATIO_TO_FLOAT32_RNE_CORE_DEFINES_SVH

`ifndef SYNTH

// Property that must hold in the same cycle.
`define R2F_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("r2f check failed");

// Consequent that must hold in the cycle after the antecedent.
`define R2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2f check failed");

`else

`define R2F_ASSERT(lbl, clk, rst_n, prop)
`define R2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/r2f_pkg.sv
package r2f_pkg;

    // Operand and result widths.
    localparam int unsigned OPND_W     = 9;
    localparam int unsigned REM_W      = OPND_W + 1;
    localparam int unsigned FRAC_BITS  = 23;
    localparam int unsigned SIG_BITS   = 24;
    localparam int unsigned EXP_BIAS   = 127;
    localparam int unsigned RESULT_W   = 30;
    localparam int unsigned EXP_FLD_W  = RESULT_W - FRAC_BITS;

    // A nonzero 9-bit numerator reaches any 9-bit denominator within 9 doublings.
    localparam int unsigned MAX_SHIFT  = OPND_W;
    localparam int unsigned SHIFT_W    = 4;

    // Quotient bits resolved per divider stage, and the number of stages.
    localparam int unsigned STEPS_PER_STAGE = 3;
    localparam int unsigned DIV_STAGES      = SIG_BITS / STEPS_PER_STAGE;

    // Work item carried down the divider pipeline.
    typedef struct packed {
        logic [REM_W-1:0]    rem;     // partial remainder, pre-doubled
        logic [OPND_W-1:0]   denom;
        logic [SIG_BITS-1:0] quo;     // quotient bits gathered so far
        logic [SHIFT_W-1:0]  shifts;  // negative exponent
        logic                ok;
    } t_work;

endpackage

FILE: hdl/r2f_norm.sv
module r2f_norm
    import r2f_pkg::*;
#(
    parameter int unsigned MAX_DENOM = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OPND_W-1:0] i_numer,
    input  logic [OPND_W-1:0] i_denom,
    output logic              o_valid,
    input  logic              i_ready,
    output t_work             o_work
);

    localparam int unsigned CAND_W = OPND_W + MAX_SHIFT;

    logic              r_vld;
    t_work             r_work;
    t_work             n_work;
    logic [CAND_W-1:0] cand;
    logic [CAND_W-1:0] scaled;
    logic [SHIFT_W-1:0] shifts;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_work  = r_work;

    // Find the smallest doubling count that lifts the numerator to the denominator.
    always_comb begin
        shifts = '0;
        scaled = CAND_W'(i_numer);
        cand   = '0;
        for (int k = MAX_SHIFT; k >= 0; k--) begin
            cand = CAND_W'(i_numer) << k;
            if (cand >= CAND_W'(i_denom)) begin
                shifts = SHIFT_W'(k);
                scaled = cand;
            end
        end
    end

    // Screen the operands and seed the divider.
    always_comb begin
        n_work        = '0;
        n_work.rem    = scaled[REM_W-1:0];
        n_work.denom  = i_denom;
        n_work.shifts = shifts;
        n_work.ok     = (i_numer != '0) && (i_denom != '0) && (i_numer <= i_denom)
                        && (32'(i_denom) <= 32'(MAX_DENOM));
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

FILE: hdl/r2f_div_stage.sv
`include "ratio_to_float32_rne_core_defines.svh"

module r2f_div_stage
    import r2f_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    logic              r_vld;
    t_work             r_work;
    t_work             n_work;
    logic              qbit;
    logic [REM_W-1:0]  part;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_work  = r_work;

    // Restoring division: compare and subtract, then double the remainder.
    always_comb begin
        n_work = i_work;
        qbit   = 1'b0;
        part   = '0;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            qbit       = n_work.rem >= REM_W'(n_work.denom);
            part       = qbit ? (n_work.rem - REM_W'(n_work.denom)) : n_work.rem;
            n_work.rem = {part[REM_W-2:0], 1'b0};
            n_work.quo = {n_work.quo[SIG_BITS-2:0], qbit};
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    // For valid operands the doubled remainder stays below twice the denominator.
    `R2F_ASSERT(a_rem_bound, i_clk, i_rst_n, !(r_vld && r_work.ok) || (r_work.rem < {r_work.denom, 1'b0}))

endmodule

FILE: hdl/r2f_round.sv
module r2f_round
    import r2f_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_work               i_work,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RESULT_W-1:0] o_float_bits,
    output logic                o_ok
);

    logic                r_vld;
    logic [RESULT_W-1:0] r_float_bits;
    logic                r_ok;
    logic [RESULT_W-1:0] n_float_bits;
    logic                round_up;
    logic [SIG_BITS:0]   sig_rnd;
    logic [SIG_BITS-1:0] sig;
    logic [7:0]          biased;

    assign o_ready      = !r_vld || i_ready;
    assign o_valid      = r_vld;
    assign o_float_bits = r_float_bits;
    assign o_ok         = r_ok;

    // Round to nearest, ties to even; the remainder arrives already doubled.
    always_comb begin
        round_up = (i_work.rem > REM_W'(i_work.denom))
                   || ((i_work.rem == REM_W'(i_work.denom)) && i_work.quo[0]);
        sig_rnd  = {1'b0, i_work.quo} + (SIG_BITS+1)'(round_up);
        biased   = 8'(EXP_BIAS) - 8'(i_work.shifts);
        sig      = sig_rnd[SIG_BITS-1:0];
        if (sig_rnd[SIG_BITS]) begin
            sig    = sig_rnd[SIG_BITS:1];
            biased = biased + 8'd1;
        end
        n_float_bits = i_work.ok ? {biased[EXP_FLD_W-1:0], sig[FRAC_BITS-1:0]} : '0;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_float_bits <= n_float_bits;
            r_ok         <= i_work.ok;
        end
    end

endmodule

FILE: hdl/ratio_to_float32_rne_core.sv
// Stages from input transfer to result valid: one screening stage,
// eight divider stages of three quotient bits each, one rounding stage.
// Throughput: one item per cycle unless the output stalls; the pipeline depth sets the latency.
// Each stage has its own valid bit, so bubbles close up under output stalls.
// Reset is synchronous and active low; it clears all valid bits, not data.
`include "ratio_to_float32_rne_core_defines.svh"

module ratio_to_float32_rne_core
    import r2f_pkg::*;
#(
    parameter int unsigned MAX_DENOM = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OPND_W-1:0]   i_numer,
    input  logic [OPND_W-1:0]   i_denom,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RESULT_W-1:0] o_float_bits,
    output logic                o_ok
);

    logic  stg_vld [DIV_STAGES+1];
    logic  stg_rdy [DIV_STAGES+1];
    t_work stg_work[DIV_STAGES+1];

    // Operand screening and normalization.
    r2f_norm #(
        .MAX_DENOM(MAX_DENOM)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_numer (i_numer),
        .i_denom (i_denom),
        .o_valid (stg_vld[0]),
        .i_ready (stg_rdy[0]),
        .o_work  (stg_work[0])
    );

    // Divider pipeline.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        r2f_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_vld[g]),
            .o_ready (stg_rdy[g]),
            .i_work  (stg_work[g]),
            .o_valid (stg_vld[g+1]),
            .i_ready (stg_rdy[g+1]),
            .o_work  (stg_work[g+1])
        );
    end

    // Rounding, packing and the output register.
    r2f_round u_round (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_vld[DIV_STAGES]),
        .o_ready      (stg_rdy[DIV_STAGES]),
        .i_work       (stg_work[DIV_STAGES]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_float_bits (o_float_bits),
        .o_ok         (o_ok)
    );

    // A rejected item always comes out as zero.
    `R2F_ASSERT(a_bad_is_zero, i_clk, i_rst_n, !(o_valid && !o_ok) || (o_float_bits == '0))
    // Valid results lie in [2^-9, 1], so the exponent field stays in range.
    `R2F_ASSERT(a_exp_range, i_clk, i_rst_n, !(o_valid && o_ok) || (o_float_bits[29:23] >= 7'd118))
    // An exponent of zero (unbiased) only ever encodes exactly one.
    `R2F_ASSERT(a_one_exact, i_clk, i_rst_n, !(o_valid && o_ok && o_float_bits[29:23] == 7'h7F) || (o_float_bits[22:0] == '0))
    // With the output free, the last divider stage always drains into it.
    `R2F_ASSERT_NEXT(a_drain, i_clk, i_rst_n, stg_vld[DIV_STAGES] && stg_rdy[DIV_STAGES], o_valid)

endmodule
